>>> hdl/cmf_pkg.sv
// Shared types and constants of the cross-shaped median filter.
`default_nettype none
package cmf_pkg;
  localparam int PIX_W       = 16;
  localparam int WIN         = 13;
  localparam int ARM         = 3;
  localparam int ROWS_KEPT   = 2 * ARM;
  localparam int VEC_N       = 2 * ARM + 1;
  localparam int RANK_W      = $clog2(WIN + 1);
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int ROWS_CFG_W  = 13;
  localparam int COLS_CFG_W  = 12;
  localparam int DEF_MAX_COLS = 2048;
  localparam int DEF_MAX_ROWS = 4096;
  localparam int RESET_DIM   = 2048;
  localparam int FIFO_DEPTH  = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic            emit;
    logic            last;
    logic [WIN-1:0]  mask;
  } win_ctl_t;

  typedef struct packed {
    logic last;
    pix_t value;
  } result_t;
endpackage
`default_nettype wire

>>> hdl/cmf_in_if.sv
// Input pixel channel.
`default_nettype none
interface cmf_in_if import cmf_pkg::*; ();
  logic valid;
  logic ready;
  logic command;
  pix_t pixel_value;
  modport source (output valid, output command, output pixel_value, input ready);
  modport sink (input valid, input command, input pixel_value, output ready);
endinterface
`default_nettype wire

>>> hdl/cmf_out_if.sv
// Result channel.
`default_nettype none
interface cmf_out_if import cmf_pkg::*; ();
  logic valid;
  logic ready;
  pix_t median_value;
  logic frame_last;
  modport source (output valid, output median_value, output frame_last, input ready);
  modport sink (input valid, input median_value, input frame_last, output ready);
endinterface
`default_nettype wire

>>> hdl/cmf_cfg_if.sv
// Configuration write channel.
`default_nettype none
interface cmf_cfg_if import cmf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/cross_median_filter_top.sv
// Top level of the streaming cross-shaped 7x7 median filter.
// Takes one pixel per clock in raster order while in_if.ready is high and returns one median per
// clock while out_if.ready is high, 3*cols+3 pixels behind its input; each pixel reads and
// rewrites one word of a single line-store RAM (MAX_COLS words of six 16-bit rows, one read and
// one write port) and a result leaves through the s1 and s2 registers and the a, b and c stages
// of the rank-median pipeline. After the last pixel of a frame, each drain beat returns one
// result; when the frame holds fewer than 3*cols+3 pixels, in_if.ready stays low while the
// window pipeline catches up. A configuration write restarts the frame.
`default_nettype none
module cross_median_filter_top import cmf_pkg::*; #(
  parameter int MAX_COLS = DEF_MAX_COLS,
  parameter int MAX_ROWS = DEF_MAX_ROWS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cmf_in_if.sink      in_if,
  cmf_out_if.source   out_if,
  cmf_cfg_if.sink     cfg_if
);
  localparam int CA  = $clog2(MAX_COLS);
  localparam int CNW = $clog2(MAX_COLS + 1);
  localparam int RA  = $clog2(MAX_ROWS);
  localparam int RNW = $clog2(MAX_ROWS + 1);
  localparam int FW  = $clog2(3 * MAX_COLS + 4);
  localparam int OW  = $clog2(FIFO_DEPTH + 1);
  localparam int MW  = ROWS_KEPT * PIX_W;

  function automatic logic [31:0] clampv(input logic [31:0] v, input logic [31:0] mx);
    logic [31:0] r;
    r = v;
    if (v == 32'd0) r = 32'd1;
    else if (v > mx) r = mx;
    return r;
  endfunction

  logic [RNW-1:0] rows_r;
  logic [CNW-1:0] cols_r;
  logic [FW-1:0]  lag;
  logic [RA-1:0]  in_row_r, out_row_r;
  logic [CA-1:0]  in_col_r, out_col_r, q_col_r;
  logic [FW-1:0]  fill_r;
  logic           in_done_r;
  logic [OW-1:0]  outst_r;

  logic acc, px, dr, catchup, adv, emit, last, credit_ok, pop, restart, cfg_wr;
  logic in_col_wrap, out_col_wrap, q_col_wrap;
  win_ctl_t ctl;

  logic     s1_valid_r, s2_valid_r;
  pix_t     s1_pix_r;
  logic [CA-1:0] s1_addr_r;
  win_ctl_t s1_ctl_r, s2_ctl_r;
  logic [MW-1:0] word, wr_word;
  pix_t     vnew [VEC_N];
  pix_t     vs_r [4][VEC_N];
  pix_t     h_r  [VEC_N];
  pix_t     win_vals [WIN];

  logic     res_valid;
  result_t  res, head;
  logic     not_empty;

  assign lag = FW'({cols_r, 1'b0}) + FW'(cols_r) + FW'(3);

  assign credit_ok = (outst_r < OW'(FIFO_DEPTH));
  assign catchup   = in_done_r && (fill_r != lag);
  assign in_if.ready = credit_ok && !catchup;
  assign acc = in_if.valid && in_if.ready;
  assign px  = acc && (in_if.command == CMD_PIXEL) && !in_done_r;
  assign dr  = acc && (in_if.command == CMD_DRAIN) && in_done_r;
  assign adv = px || dr || catchup;
  assign emit = adv && (fill_r == lag);
  assign last = ((RNW'(out_row_r) + RNW'(1)) == rows_r) &&
                ((CNW'(out_col_r) + CNW'(1)) == cols_r);
  assign restart = emit && last;
  assign cfg_wr  = cfg_if.valid && cfg_if.ready;
  assign cfg_if.ready = 1'b1;

  assign in_col_wrap  = (CNW'(in_col_r) + CNW'(1)) == cols_r;
  assign out_col_wrap = (CNW'(out_col_r) + CNW'(1)) == cols_r;
  assign q_col_wrap   = (CNW'(q_col_r) + CNW'(1)) == cols_r;

  always_comb begin
    ctl.emit = emit;
    ctl.last = last;
    ctl.mask[0] = 1'b1;
    for (int d = 1; d <= ARM; d++) begin
      ctl.mask[d]           = (CNW'(out_col_r) >= CNW'(d));
      ctl.mask[ARM + d]     = ((CNW + 2)'(out_col_r) + (CNW + 2)'(d)) < (CNW + 2)'(cols_r);
      ctl.mask[2 * ARM + d] = (RNW'(out_row_r) >= RNW'(d));
      ctl.mask[3 * ARM + d] = ((RNW + 2)'(out_row_r) + (RNW + 2)'(d)) < (RNW + 2)'(rows_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= RNW'(clampv(32'(RESET_DIM), 32'(MAX_ROWS)));
      cols_r    <= CNW'(clampv(32'(RESET_DIM), 32'(MAX_COLS)));
      in_row_r  <= '0;
      in_col_r  <= '0;
      out_row_r <= '0;
      out_col_r <= '0;
      q_col_r   <= '0;
      fill_r    <= '0;
      in_done_r <= 1'b0;
      outst_r   <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      outst_r    <= outst_r + OW'(emit) - OW'(pop);
      s1_valid_r <= adv;
      s2_valid_r <= s1_valid_r && s1_ctl_r.emit;
      if (cfg_wr || restart) begin
        in_row_r  <= '0;
        in_col_r  <= '0;
        out_row_r <= '0;
        out_col_r <= '0;
        q_col_r   <= '0;
        fill_r    <= '0;
        in_done_r <= 1'b0;
        if (cfg_wr) begin
          unique case (cfg_if.index)
            CFG_ROWS: rows_r <= RNW'(clampv(32'(cfg_if.data[ROWS_CFG_W-1:0]), 32'(MAX_ROWS)));
            CFG_COLS: cols_r <= CNW'(clampv(32'(cfg_if.data[COLS_CFG_W-1:0]), 32'(MAX_COLS)));
            default: ;
          endcase
        end
      end else begin
        if (px) begin
          if (in_col_wrap) begin
            in_col_r <= '0;
            if ((RNW'(in_row_r) + RNW'(1)) == rows_r) begin
              in_row_r  <= '0;
              in_done_r <= 1'b1;
            end else begin
              in_row_r <= in_row_r + RA'(1);
            end
          end else begin
            in_col_r <= in_col_r + CA'(1);
          end
        end
        if (adv) begin
          q_col_r <= q_col_wrap ? '0 : q_col_r + CA'(1);
          if (fill_r != lag) fill_r <= fill_r + FW'(1);
        end
        if (emit) begin
          if (out_col_wrap) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + RA'(1);
          end else begin
            out_col_r <= out_col_r + CA'(1);
          end
        end
      end
    end
    if (adv) begin
      s1_pix_r  <= in_if.pixel_value;
      s1_addr_r <= q_col_r;
      s1_ctl_r  <= ctl;
    end
    s2_ctl_r <= s1_ctl_r;
    if (s1_valid_r) begin
      vs_r[0] <= vnew;
      for (int i = 1; i < 4; i++) vs_r[i] <= vs_r[i-1];
      h_r[0] <= vnew[ARM];
      for (int j = 1; j < VEC_N; j++) h_r[j] <= h_r[j-1];
    end
  end

  cmf_line_mem #(.ADDR_W(CA), .DATA_W(MW)) u_mem (
    .clk     (clk),
    .rd_en   (adv),
    .rd_addr (q_col_r),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_addr_r),
    .wr_data (wr_word),
    .rd_data (word)
  );

  assign wr_word = {word[MW-PIX_W-1:0], s1_pix_r};

  always_comb begin
    vnew[0] = s1_pix_r;
    for (int k = 1; k < VEC_N; k++) vnew[k] = word[(k-1)*PIX_W +: PIX_W];
    win_vals[0] = vs_r[3][ARM];
    for (int d = 1; d <= ARM; d++) begin
      win_vals[d]           = h_r[ARM + d];
      win_vals[ARM + d]     = h_r[ARM - d];
      win_vals[2 * ARM + d] = vs_r[3][ARM + d];
      win_vals[3 * ARM + d] = vs_r[3][ARM - d];
    end
  end

  cmf_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_vals   (win_vals),
    .in_ctl    (s2_ctl_r),
    .res_valid (res_valid),
    .res       (res)
  );

  cmf_out_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  assign pop                 = out_if.valid && out_if.ready;
  assign out_if.valid        = not_empty;
  assign out_if.median_value = head.value;
  assign out_if.frame_last   = head.last;
endmodule
`default_nettype wire

>>> hdl/cmf_line_mem.sv
// Line store: one word per column holding six rows, read-first with write forwarding.
`default_nettype none
module cmf_line_mem import cmf_pkg::*; #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = ROWS_KEPT * PIX_W
) (
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  output logic      [DATA_W-1:0] rd_data
);
  logic [DATA_W-1:0] mem [2**ADDR_W];
  logic [DATA_W-1:0] rd_q_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic              fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_r      <= wr_en && (wr_addr == rd_addr);
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;
endmodule
`default_nettype wire

>>> hdl/cmf_median.sv
// Three-stage rank-based median of up to 13 masked window values.
`default_nettype none
module cmf_median import cmf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire pix_t     in_vals [WIN],
  input  wire win_ctl_t in_ctl,
  output logic          res_valid,
  output result_t       res
);
  logic [WIN-1:0]    lt [WIN];
  logic [WIN-1:0]    lt_r [WIN];
  pix_t              a_vals_r [WIN];
  logic [WIN-1:0]    a_mask_r;
  logic              a_last_r;
  logic [RANK_W-1:0] a_n_r;
  logic              a_valid_r;

  logic [RANK_W-1:0] b_rank_r [WIN];
  pix_t              b_vals_r [WIN];
  logic [WIN-1:0]    b_mask_r;
  logic              b_last_r;
  logic [RANK_W-1:0] b_n_r;
  logic              b_valid_r;

  logic [RANK_W-1:0] lo_idx, hi_idx;
  pix_t              lo_val, hi_val;
  logic [PIX_W:0]    sum;
  logic              c_valid_r;
  result_t           c_res_r;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        lt[i][j] = in_ctl.mask[j] && (j != i) &&
                   ((in_vals[j] < in_vals[i]) || ((in_vals[j] == in_vals[i]) && (j < i)));
      end
    end
  end

  always_comb begin
    lo_idx = (b_n_r - RANK_W'(1)) >> 1;
    hi_idx = b_n_r >> 1;
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < WIN; i++) begin
      if (b_mask_r[i] && (b_rank_r[i] == lo_idx)) lo_val = lo_val | b_vals_r[i];
      if (b_mask_r[i] && (b_rank_r[i] == hi_idx)) hi_val = hi_val | b_vals_r[i];
    end
    sum = {1'b0, lo_val} + {1'b0, hi_val};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
      c_valid_r <= b_valid_r;
    end
    lt_r     <= lt;
    a_vals_r <= in_vals;
    a_mask_r <= in_ctl.mask;
    a_last_r <= in_ctl.last;
    a_n_r    <= RANK_W'($countones(in_ctl.mask));
    for (int i = 0; i < WIN; i++) begin
      b_rank_r[i] <= RANK_W'($countones(lt_r[i]));
    end
    b_vals_r      <= a_vals_r;
    b_mask_r      <= a_mask_r;
    b_last_r      <= a_last_r;
    b_n_r         <= a_n_r;
    c_res_r.value <= sum[PIX_W:1];
    c_res_r.last  <= b_last_r;
  end

  assign res_valid = c_valid_r;
  assign res       = c_res_r;
endmodule
`default_nettype wire

>>> hdl/cmf_out_fifo.sv
// Small result queue in front of the output channel.
`default_nettype none
module cmf_out_fifo import cmf_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire result_t push_data,
  input  wire logic    pop,
  output logic         not_empty,
  output result_t      head
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  result_t       q_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      count_r <= count_r + CW'(push) - CW'(pop);
    end
    if (push) q_r[wr_ptr_r] <= push_data;
  end

  assign not_empty = (count_r != '0);
  assign head      = q_r[rd_ptr_r];
endmodule
`default_nettype wire

>>> hdl/cmf_checker.sv
// Port-level assertions for the median filter, bound to the top level.
`default_nettype none
module cmf_checker import cmf_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire pix_t out_value,
  input wire logic out_last
);
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_last))
    else $error("stalled result changed");
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid) else $error("result right after reset");
  a_pipe_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n, 2) |-> !out_valid) else $error("result faster than pipeline");
endmodule

bind cross_median_filter_top cmf_checker u_cmf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_value (out_if.median_value),
  .out_last  (out_if.frame_last)
);
`default_nettype wire

>>> tb/cmf_tb_if.sv
// Testbench-side note: channel interfaces come from the RTL; this file holds the cycle watchdog.
`timescale 1ns / 100ps
module cmf_watchdog #(
  parameter int LIMIT = 200000
) (
  input  wire logic clk,
  input  wire logic active,
  output logic      expired
);
  int idle_cycles = 0;

  initial expired = 1'b0;

  always @(posedge clk) begin
    if (active) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= LIMIT) begin
      expired <= 1'b1;
    end
  end
endmodule

>>> tb/cross_median_filter_top_tb.sv
// Self-checking testbench of the cross-shaped median filter: predicted medians vs. output beats.
`timescale 1ns / 100ps
module cross_median_filter_top_tb;
  import cmf_pkg::*;

  localparam int MAXC = 2048;
  localparam int MAXR = 4096;
  localparam int RING = 6 * MAXC + 4;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cmf_in_if  in_if ();
  cmf_out_if out_if ();
  cmf_cfg_if cfg_if ();

  cross_median_filter_top uut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  pix_t    pix_hist [RING];
  int      rows_reg, cols_reg;
  int      in_r, in_c, out_r, out_c;
  bit      frame_in_done;
  result_t median_q [$];
  int      errors = 0;
  int      hold_off = 0;
  bit      idle_en = 1'b1;
  logic    expired;
  bit      dim_sel;

  wire in_acc  = in_if.valid && in_if.ready;
  wire out_acc = out_if.valid && out_if.ready;
  wire cfg_acc = cfg_if.valid && cfg_if.ready;

  cmf_watchdog #(.LIMIT(60000)) wd (
    .clk(clk), .active(in_acc || out_acc || cfg_acc), .expired(expired)
  );

  function automatic int rows_eff();
    return rows_reg < 1 ? 1 : (rows_reg > MAXR ? MAXR : rows_reg);
  endfunction

  function automatic int cols_eff();
    return cols_reg < 1 ? 1 : (cols_reg > MAXC ? MAXC : cols_reg);
  endfunction

  function automatic int ring_slot(int r, int c);
    longint flat;
    flat = longint'(r) * cols_eff() + c;
    return int'(flat % RING);
  endfunction

  function automatic void restart_positions();
    in_r = 0; in_c = 0; out_r = 0; out_c = 0;
    frame_in_done = 1'b0;
  endfunction

  function automatic void push_median();
    pix_t    v [WIN];
    pix_t    t;
    int      n, rows, cols, r, c, j;
    result_t res;
    rows = rows_eff();
    cols = cols_eff();
    r = out_r;
    c = out_c;
    n = 0;
    v[n++] = pix_hist[ring_slot(r, c)];
    for (int d = 1; d <= ARM; d++) begin
      if (c >= d) v[n++] = pix_hist[ring_slot(r, c - d)];
      if (c + d < cols) v[n++] = pix_hist[ring_slot(r, c + d)];
      if (r >= d) v[n++] = pix_hist[ring_slot(r - d, c)];
      if (r + d < rows) v[n++] = pix_hist[ring_slot(r + d, c)];
    end
    for (int i = 1; i < n; i++) begin
      t = v[i];
      j = i;
      while (j > 0 && v[j-1] > t) begin
        v[j] = v[j-1];
        j--;
      end
      v[j] = t;
    end
    if (n % 2) res.value = v[n/2];
    else res.value = pix_t'((32'(v[n/2-1]) + 32'(v[n/2])) >> 1);
    res.last = (r + 1 >= rows) && (c + 1 >= cols);
    median_q.push_back(res);
    if (res.last) begin
      restart_positions();
    end else begin
      out_c = c + 1;
      if (out_c >= cols) begin
        out_c = 0;
        out_r = r + 1;
      end
    end
  endfunction

  function automatic void predict_beat(logic cmd, pix_t pix);
    longint received;
    int cols;
    cols = cols_eff();
    if (cmd == CMD_DRAIN) begin
      if (frame_in_done) push_median();
      return;
    end
    if (frame_in_done) return;
    pix_hist[ring_slot(in_r, in_c)] = pix;
    received = longint'(in_r) * cols + in_c + 1;
    in_c++;
    if (in_c >= cols) begin
      in_c = 0;
      in_r++;
      if (in_r >= rows_eff()) begin
        in_r = 0;
        frame_in_done = 1'b1;
      end
    end
    if (received > 3 * longint'(cols) + 3) push_median();
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_acc) begin
        if (cfg_if.index == CFG_ROWS) rows_reg = int'(cfg_if.data);
        else cols_reg = int'(cfg_if.data & 13'hFFF);
        restart_positions();
      end
      if (in_acc) predict_beat(in_if.command, in_if.pixel_value);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_acc) begin
      if (median_q.size() == 0) begin
        report_mismatch("unexpected beat, median", out_if.median_value, -1);
      end else begin
        want = median_q.pop_front();
        if (out_if.median_value !== want.value)
          report_mismatch("median_value", out_if.median_value, want.value);
        if (out_if.frame_last !== want.last)
          report_mismatch("frame_last", out_if.frame_last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_if.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else begin
      out_if.ready <= !idle_en || ($urandom_range(99) >= 37);
    end
  end

  task automatic send_beat(logic cmd, pix_t pix);
    while (idle_en && $urandom_range(99) < 37) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.command <= cmd;
    in_if.pixel_value <= pix;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_frame(int rows, int cols);
    wait_idle();
    write_reg(CFG_ROWS, rows);
    write_reg(CFG_COLS, cols);
  endtask

  function automatic pix_t rand_pix(int mode);
    case (mode)
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic run_frame(int mode);
    int n;
    n = rows_eff() * cols_eff();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 3) send_beat(CMD_DRAIN, rand_pix(2));
      send_beat(CMD_PIXEL, rand_pix(mode == 3 ? $urandom_range(2) : mode));
    end
    if ($urandom_range(3) == 0) send_beat(CMD_PIXEL, rand_pix(2));
    for (int i = 0; i < n && i < 3 * cols_eff() + 3; i++)
      send_beat(CMD_DRAIN, rand_pix(2));
  endtask

  task automatic test_directed();
    set_frame(1, 1);
    send_beat(CMD_DRAIN, 16'hFFFF);
    send_beat(CMD_PIXEL, 16'hFFFF);
    send_beat(CMD_PIXEL, 16'h1234);
    send_beat(CMD_DRAIN, 16'h0000);
    set_frame(0, 0);
    run_frame(1);
    set_frame(2, 2);
    run_frame(3);
    set_frame(3, 5);
    run_frame(0);
    set_frame(8191, 4095);
    wait_idle();
    set_frame(4, 4);
    run_frame(1);
  endtask

  task automatic test_random();
    for (int f = 0; f < 25; f++) begin
      set_frame($urandom_range(8, 1), $urandom_range(10, 1));
      if (f == 10) idle_en = 1'b0;
      if (f == 16) idle_en = 1'b1;
      if ($urandom_range(9) == 0) begin
        for (int i = 0; i < 5; i++) send_beat(CMD_PIXEL, rand_pix(2));
      end else begin
        run_frame(3);
      end
    end
  endtask

  task automatic test_backpressure();
    set_frame(12, 16);
    hold_off = 400;
    run_frame(2);
  endtask

  task automatic test_wide_row();
    set_frame(2, 96);
    run_frame(2);
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.command = CMD_PIXEL;
    in_if.pixel_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ROWS;
    cfg_if.data = '0;
    rows_reg = RESET_DIM;
    cols_reg = RESET_DIM;
    restart_positions();
    foreach (pix_hist[i]) pix_hist[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    test_wide_row();
    wait_idle();
    if (errors == 0 && median_q.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    @(posedge expired);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
